// ----- src/analog_key_rapid_trigger_assert.svh -----
// Assertion macros for the analog key block checker.
`ifndef ANALOG_KEY_RAPID_TRIGGER_ASSERT_SVH
`define ANALOG_KEY_RAPID_TRIGGER_ASSERT_SVH
// Check an implication on every clock edge outside reset.
`define AKRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Check a next-cycle implication outside reset.
`define AKRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// ----- src/akrt_pkg.sv -----
`default_nettype none
package akrt_pkg;
    localparam int TRAVEL_W = 8;
    localparam logic [2:0] ST_RESET = 3'd0;
    localparam logic [2:0] ST_RAPID = 3'd1;
    localparam logic [2:0] ST_MAYBE_TAP = 3'd2;
    localparam logic [2:0] ST_TAP = 3'd3;
    localparam logic [2:0] ST_TRIG = 3'd4;
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_DOWN = 2'd1;
    localparam logic [1:0] DIR_UP = 2'd2;
    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_PRESS = 3'd1;
    localparam logic [2:0] EV_RELEASE = 3'd2;
    localparam logic [2:0] EV_PRESS_TAP = 3'd3;
    localparam logic [2:0] EV_RELEASE_TAP = 3'd4;
    localparam logic [2:0] CFG_TRIGGER = 3'd0;
    localparam logic [2:0] CFG_RESET_GAP = 3'd1;
    localparam logic [2:0] CFG_RAPID = 3'd2;
    localparam logic [2:0] CFG_TAP = 3'd3;
    localparam logic [2:0] CFG_IDLE_MARGIN = 3'd4;
    localparam logic [2:0] CFG_SNAP = 3'd5;
    localparam logic [2:0] CFG_SLEEP = 3'd6;
    localparam logic [2:0] CFG_CALIB = 3'd7;

    typedef struct packed {
        logic [1:0]  key_index;
        logic [11:0] sample;
    } in_beat_t;

    typedef struct packed {
        logic [1:0] out_key;
        logic [2:0] event_res;
        logic [7:0] travel;
        logic [2:0] key_status;
        logic       sleeping;
    } out_beat_t;

    typedef struct packed {
        logic [7:0]  trigger_level;
        logic [7:0]  reset_gap;
        logic [7:0]  rapid_offset;
        logic        tap_enabled;
        logic [11:0] idle_margin;
        logic [11:0] top_snap_margin;
        logic [15:0] sleep_after;
        logic [7:0]  calib_samples;
    } cfg_t;

    typedef struct packed {
        logic [15:0] idle_level;
        logic [7:0]  calib_count;
        logic [12:0] max_travel;
        logic [12:0] last_distance;
        logic [11:0] filtered_travel;
        logic [8:0]  last_velocity;
        logic [7:0]  travel_now;
        logic [1:0]  moving_dir;
        logic [7:0]  turn_point;
        logic [2:0]  act_status;
        logic        triggered_flag;
        logic [15:0] idle_count;
        logic        idle_flag;
    } key_state_t;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_TRACK, S_DIV, S_FINISH, S_OUT
    } seq_state_t;

    // Divider handshake.
    typedef struct packed {
        logic        start;
        logic [20:0] dividend;
        logic [12:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [20:0] quotient;
    } div_rsp_t;
endpackage
`default_nettype wire

// ----- src/akrt_div.sv -----
`default_nettype none
module akrt_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire akrt_pkg::div_req_t req,
    output akrt_pkg::div_rsp_t     rsp
);
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [20:0] q_reg, q_next;
    logic [13:0] rem_reg, rem_next;
    logic [12:0] d_reg, d_next;
    logic        done_reg, done_next;
    logic [13:0] trial;

    always_comb
    begin
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        q_next = q_reg;
        rem_next = rem_reg;
        d_next = d_reg;
        done_next = 1'b0;
        trial = {rem_reg[12:0], q_reg[20]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next = 5'd0;
            q_next = req.dividend;
            rem_next = 14'd0;
            d_next = req.divisor;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle, restoring
            if (trial >= {1'b0, d_reg})
            begin
                rem_next = trial - {1'b0, d_reg};
                q_next = {q_reg[19:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next = {q_reg[19:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd20)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        rem_reg <= rem_next;
        d_reg <= d_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = q_reg;
endmodule
`default_nettype wire

// ----- src/akrt_mem.sv -----
`default_nettype none
module akrt_mem #(
    parameter int NUM_KEYS = 4,
    parameter int INITIAL_IDLE = 2000,
    parameter int INITIAL_MAX_TRAVEL = 500
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [1:0]            raddr,
    input  wire logic                  we,
    input  wire logic [1:0]            waddr,
    input  wire akrt_pkg::key_state_t  wdata,
    output akrt_pkg::key_state_t       rdata
);
    localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    akrt_pkg::key_state_t mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] valid_reg;
    akrt_pkg::key_state_t q_reg;
    logic hit_reg;
    akrt_pkg::key_state_t init_st;
    logic [AW-1:0] ra, wa;

    assign ra = AW'(raddr);
    assign wa = AW'(waddr);

    always_comb
    begin
        init_st = '0;
        init_st.idle_level = 16'(INITIAL_IDLE);
        init_st.max_travel = 13'(INITIAL_MAX_TRAVEL);
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wdata;
        q_reg <= mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (we)
                valid_reg[wa] <= 1'b1;
            hit_reg <= valid_reg[ra];
        end
    end

    assign rdata = hit_reg ? q_reg : init_st;
endmodule
`default_nettype wire

// ----- src/analog_key_rapid_trigger.sv -----
// Analog key rapid trigger for hall-effect keys.
// in: in_valid/in_stall carry one sample beat (key_index, sample).
// out: out_valid/out_stall carry one result beat per sample.
// cfg: cfg_valid/cfg_ready write register cfg_index with cfg_data; write
//   only while idle.
// Per-key state sits in one memory read, updated and written back.
// From input accept to out_valid a sample passes memory read, tracking,
// a 21-step serial divider for travel scaling, actuation.
// One sample at a time; no new sample is taken until the sequencer is idle again.
// An out-of-range key skips the divider.
// Reset clears configuration to defaults and marks every key unwritten so
// it reads as its reset state; no clearing pass.
// While out_stall is high the result beat holds; a new sample may be taken
// in meanwhile and waits in the pipeline until the beat leaves.
`default_nettype none
module analog_key_rapid_trigger #(
    parameter int NUM_KEYS = 4,
    parameter int SAMPLE_BITS = 12,
    parameter int INITIAL_IDLE = 2000,
    parameter int INITIAL_MAX_TRAVEL = 500
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire akrt_pkg::in_beat_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output akrt_pkg::out_beat_t       out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [15:0]          cfg_data
);
    akrt_pkg::cfg_t cfg_reg;
    akrt_pkg::seq_state_t st_reg, st_next;
    logic [1:0] key_reg;
    logic [15:0] val_reg;
    akrt_pkg::key_state_t ks_reg, ks_next, rd;
    akrt_pkg::div_req_t dreq;
    akrt_pkg::div_rsp_t drsp;
    logic [12:0] dist_reg, dist_next;
    logic oor_reg;
    akrt_pkg::out_beat_t ob_reg, ob_next;
    logic ov_reg;
    logic we;
    logic skip_reg, skip_next;
    logic accept, mem_we;
    akrt_pkg::key_state_t fin;

    assign cfg_ready = 1'b1;
    assign accept = in_valid && !in_stall;
    assign in_stall = (st_reg != akrt_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_level <= 8'd128;
            cfg_reg.reset_gap <= 8'd20;
            cfg_reg.rapid_offset <= 8'd0;
            cfg_reg.tap_enabled <= 1'b0;
            cfg_reg.idle_margin <= 12'd50;
            cfg_reg.top_snap_margin <= 12'd50;
            cfg_reg.sleep_after <= 16'd1000;
            cfg_reg.calib_samples <= 8'd100;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                akrt_pkg::CFG_TRIGGER: cfg_reg.trigger_level <= cfg_data[7:0];
                akrt_pkg::CFG_RESET_GAP: cfg_reg.reset_gap <= cfg_data[7:0];
                akrt_pkg::CFG_RAPID: cfg_reg.rapid_offset <= cfg_data[7:0];
                akrt_pkg::CFG_TAP: cfg_reg.tap_enabled <= cfg_data[0];
                akrt_pkg::CFG_IDLE_MARGIN: cfg_reg.idle_margin <= cfg_data[11:0];
                akrt_pkg::CFG_SNAP: cfg_reg.top_snap_margin <= cfg_data[11:0];
                akrt_pkg::CFG_SLEEP: cfg_reg.sleep_after <= cfg_data;
                akrt_pkg::CFG_CALIB: cfg_reg.calib_samples <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // write back the fully updated state of the key
    akrt_mem #(
        .NUM_KEYS(NUM_KEYS),
        .INITIAL_IDLE(INITIAL_IDLE),
        .INITIAL_MAX_TRAVEL(INITIAL_MAX_TRAVEL)
    ) u_mem (
        .clk(clk), .rst_n(rst_n),
        .raddr(accept ? in_data.key_index : key_reg),
        .we(mem_we), .waddr(key_reg), .wdata(fin), .rdata(rd)
    );

    akrt_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // tracking front half, before the divide
    logic [19:0] iv;
    logic [15:0] v16, idle_n;
    logic [19:0] top;
    logic [20:0] dsum;
    logic [12:0] dsat, mx;
    logic [13:0] snap;
    logic [8:0]  d8;
    logic [19:0] filt;
    logic [7:0]  f8o, f8n;
    logic signed [8:0] vel;
    logic [15:0] vcur;
    logic track_skip;
    logic [12:0] dd;

    always_comb
    begin
        ks_next = ks_reg;
        dist_next = dist_reg;
        skip_next = skip_reg;
        iv = '0; v16 = '0; idle_n = '0; top = '0; dsum = '0;
        dsat = '0; mx = '0; snap = '0; track_skip = 1'b0; vcur = val_reg;
        dreq = '0;
        dd = '0;
        if (st_reg == akrt_pkg::S_TRACK)
        begin
            ks_next = rd;
            if (rd.calib_count < cfg_reg.calib_samples)
            begin
                iv = 20'((102 * {val_reg[11:0], 4'd0} + 154 * rd.idle_level) >> 8);
                ks_next.idle_level = iv[15:0];
                if (rd.calib_count != 8'd255)
                    ks_next.calib_count = rd.calib_count + 8'd1;
                track_skip = 1'b1;
            end
            else
            begin
                idle_n = rd.idle_level;
                if ({val_reg[11:0], 4'd0} < rd.idle_level)
                begin
                    iv = 20'((51 * {val_reg[11:0], 4'd0} + 205 * rd.idle_level) >> 8);
                    idle_n = iv[15:0];
                    vcur = {4'd0, idle_n[15:4]};
                end
                ks_next.idle_level = idle_n;
                v16 = {vcur[11:0], 4'd0};
                top = {4'd0, idle_n} + {4'd0, cfg_reg.idle_margin, 4'd0};
                if (rd.last_distance == 13'd0 && {4'd0, v16} <= top)
                begin
                    if (rd.idle_count >= cfg_reg.sleep_after)
                    begin
                        ks_next.idle_flag = 1'b1;
                        track_skip = 1'b1;
                    end
                    else
                        ks_next.idle_count = rd.idle_count + 16'd1;
                end
                if ({4'd0, v16} <= top)
                begin
                    dsat = 13'd0;
                    if (!track_skip)
                        ks_next.turn_point = 8'd0;
                end
                else
                begin
                    dsum = 21'(({5'd0, v16} + {5'd0, cfg_reg.idle_margin, 4'd0}
                        - {5'd0, idle_n}) >> 4);
                    dsat = (dsum > 21'd8191) ? 13'd8191 : dsum[12:0];
                    ks_next.idle_flag = 1'b0;
                    ks_next.idle_count = 16'd0;
                end
                mx = (dsat > rd.max_travel) ? dsat : rd.max_travel;
                if (!track_skip)
                    ks_next.max_travel = mx;
                snap = {1'b0, dsat} + {2'd0, cfg_reg.top_snap_margin};
                dd = (snap >= {1'b0, mx}) ? mx : dsat;
                dist_next = dd;
                dreq.start = !track_skip && (mx != 13'd0);
                dreq.dividend = 21'(dd * 255);
                dreq.divisor = mx;
            end
            skip_next = track_skip;
        end
    end

    // back half: filter, direction, actuation, tap check
    logic [2:0] ev;
    logic signed [9:0] dval, rlvl, rplvl;
    logic after_trig, before_reset, has_rapid, after_rapid, before_rapid;

    always_comb
    begin
        fin = ks_reg;
        ev = akrt_pkg::EV_NONE;
        d8 = '0; filt = '0; f8o = '0; f8n = '0; vel = '0;
        dval = '0; rlvl = '0; rplvl = '0;
        after_trig = 1'b0; before_reset = 1'b0; has_rapid = 1'b0;
        after_rapid = 1'b0; before_rapid = 1'b0;
        if (!skip_reg)
        begin
            if (ks_reg.max_travel == 13'd0 || drsp.quotient > 21'd255)
                d8 = 9'd255;
            else
                d8 = drsp.quotient[8:0];
            filt = 20'((51 * {d8[7:0], 4'd0} + 205 * ks_reg.filtered_travel) >> 8);
            f8o = ks_reg.filtered_travel[11:4];
            f8n = filt[11:4];
            vel = $signed({1'b0, f8n}) - $signed({1'b0, f8o});
            if ($signed(ks_reg.last_velocity) > 0 && vel > 0
                && ks_reg.moving_dir != akrt_pkg::DIR_DOWN)
            begin
                fin.moving_dir = akrt_pkg::DIR_DOWN;
                if (ks_reg.turn_point != 8'd0) fin.turn_point = f8o;
            end
            else if ($signed(ks_reg.last_velocity) < 0 && vel < 0
                && ks_reg.moving_dir != akrt_pkg::DIR_UP)
            begin
                fin.moving_dir = akrt_pkg::DIR_UP;
                if (ks_reg.turn_point != 8'd255) fin.turn_point = f8o;
            end
            fin.last_distance = dist_reg;
            fin.filtered_travel = filt[11:0];
            fin.last_velocity = vel;
            fin.travel_now = d8[7:0];

            dval = $signed({2'd0, d8[7:0]});
            rlvl = $signed({2'd0, cfg_reg.trigger_level}) - $signed({2'd0, cfg_reg.reset_gap});
            rplvl = $signed({2'd0, fin.turn_point}) - $signed({2'd0, cfg_reg.rapid_offset});
            after_trig = dval > $signed({2'd0, cfg_reg.trigger_level});
            before_reset = dval < rlvl;
            has_rapid = cfg_reg.rapid_offset != 8'd0;
            after_rapid = dval > (rplvl + $signed({2'd0, cfg_reg.reset_gap}));
            before_rapid = dval < rplvl;
            case (fin.act_status)
                akrt_pkg::ST_RESET:
                    if (after_trig)
                    begin
                        if (cfg_reg.tap_enabled)
                            fin.act_status = akrt_pkg::ST_MAYBE_TAP;
                        else
                        begin
                            fin.act_status = akrt_pkg::ST_TRIG;
                            fin.triggered_flag = 1'b1;
                            ev = akrt_pkg::EV_PRESS;
                        end
                    end
                akrt_pkg::ST_RAPID:
                    if (!has_rapid)
                        fin.act_status = akrt_pkg::ST_RESET;
                    else if (after_trig && fin.moving_dir == akrt_pkg::DIR_DOWN && after_rapid)
                    begin
                        fin.triggered_flag = 1'b1;
                        if (cfg_reg.tap_enabled)
                            fin.act_status = akrt_pkg::ST_MAYBE_TAP;
                        else
                        begin
                            fin.act_status = akrt_pkg::ST_TRIG;
                            ev = akrt_pkg::EV_PRESS;
                        end
                    end
                    else if (before_reset)
                        fin.act_status = akrt_pkg::ST_RESET;
                akrt_pkg::ST_TAP:
                begin
                    fin.act_status = akrt_pkg::ST_RESET;
                    fin.triggered_flag = 1'b0;
                    ev = akrt_pkg::EV_RELEASE_TAP;
                end
                akrt_pkg::ST_TRIG:
                    if (before_reset)
                    begin
                        fin.act_status = akrt_pkg::ST_RESET;
                        fin.triggered_flag = 1'b0;
                        ev = akrt_pkg::EV_RELEASE;
                    end
                    else if (has_rapid && fin.moving_dir == akrt_pkg::DIR_UP && before_rapid)
                    begin
                        fin.act_status = akrt_pkg::ST_RAPID;
                        fin.triggered_flag = 1'b0;
                        ev = akrt_pkg::EV_RELEASE;
                    end
                default: ;
            endcase
        end
        rlvl = $signed({2'd0, cfg_reg.trigger_level}) - $signed({2'd0, cfg_reg.reset_gap});
        if (fin.act_status == akrt_pkg::ST_MAYBE_TAP
            && $signed({2'd0, fin.travel_now}) < rlvl)
        begin
            fin.act_status = akrt_pkg::ST_TAP;
            ev = akrt_pkg::EV_PRESS_TAP;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            akrt_pkg::S_IDLE: if (accept) st_next = akrt_pkg::S_READ;
            akrt_pkg::S_READ: st_next = oor_reg ? akrt_pkg::S_OUT : akrt_pkg::S_TRACK;
            akrt_pkg::S_TRACK: st_next = dreq.start ? akrt_pkg::S_DIV : akrt_pkg::S_FINISH;
            akrt_pkg::S_DIV: if (drsp.done) st_next = akrt_pkg::S_FINISH;
            akrt_pkg::S_FINISH: st_next = akrt_pkg::S_OUT;
            akrt_pkg::S_OUT: if (!ov_reg || !out_stall) st_next = akrt_pkg::S_IDLE;
            default: st_next = akrt_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        mem_we = (st_reg == akrt_pkg::S_FINISH);
        we = (st_reg == akrt_pkg::S_OUT) && (!ov_reg || !out_stall);
        ob_next = ob_reg;
        if (st_reg == akrt_pkg::S_FINISH)
        begin
            ob_next.out_key = key_reg;
            ob_next.event_res = ev;
            ob_next.travel = fin.travel_now;
            ob_next.key_status = fin.act_status;
            ob_next.sleeping = fin.idle_flag;
        end
        else if (st_reg == akrt_pkg::S_READ && oor_reg)
        begin
            ob_next = '0;
            ob_next.out_key = key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= akrt_pkg::S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (we)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    akrt_pkg::out_beat_t res_reg;
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= in_data.key_index;
            val_reg <= 16'(in_data.sample & 12'((1 << SAMPLE_BITS) - 1));
            oor_reg <= (32'(in_data.key_index) >= NUM_KEYS);
        end
        if (st_reg == akrt_pkg::S_TRACK)
            ks_reg <= ks_next;
        else if (st_reg == akrt_pkg::S_FINISH)
            ks_reg <= fin;
        dist_reg <= dist_next;
        skip_reg <= skip_next;
        ob_reg <= ob_next;
        if (we)
            res_reg <= ob_reg;
    end

    assign out_valid = ov_reg;
    assign out_data = res_reg;
endmodule
`default_nettype wire

// ----- src/akrt_checker.sv -----
`default_nettype none
`include "analog_key_rapid_trigger_assert.svh"
module akrt_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire akrt_pkg::out_beat_t out_data
);
    `AKRT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
    `AKRT_ASSERT_IMP(a_event_range, clk, rst_n, out_valid, out_data.event_res <= akrt_pkg::EV_RELEASE_TAP)
    `AKRT_ASSERT_IMP(a_status_range, clk, rst_n, out_valid, out_data.key_status <= akrt_pkg::ST_TRIG)
    `AKRT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
endmodule

bind analog_key_rapid_trigger akrt_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire
